/* design/sbs_pkg.sv */
`default_nettype none
package sbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int CMD_W    = 2;
   localparam int ID_W     = 31;
   localparam int GRADE_W  = 7;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 10;
   localparam int REC_W    = ID_W + 2 * GRADE_W;

   // The weighted sum plus one is at most 382, so it needs nine bits.
   localparam int SUM_W       = GRADE_W + 2;
   localparam int GRADE_RECIP = 683;
   localparam int GRADE_SHIFT = 11;
   localparam int PROD_W      = SUM_W + 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_CLEARED  = 3'd0,
      STATUS_APPENDED = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_FOUND    = 3'd3,
      STATUS_MISSING  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_GRADE
   } state_type;

endpackage
`default_nettype wire

/* design/sbs_ram.sv */
`default_nettype none
module sbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/sorted_table_binary_search.sv */
// Channel    Direction  Handshake           Payload
// request    in         start and not busy  req_cmd, req_record_id, req_first_grade,
//                                           req_second_grade, req_search_key
// response   out        rsp_valid strobe    rsp_status, rsp_found_index, rsp_found_id,
//                                           rsp_final_grade
//
// Clear, append and unused commands answer one cycle after acceptance and keep busy low.
// A search probes one entry per cycle through the single read port and the shared compare
// and halving unit, up to 11 probes for 1024 entries; a miss is answered from the response
// registers after its last probe, while a hit passes through the grade state first.
// Reset empties the table at once; the stored records need no clearing pass.
// Each result is shown for one cycle only and the receiver cannot stall it.
`default_nettype none
module sorted_table_binary_search (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [sbs_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [sbs_pkg::ID_W-1:0]       req_record_id,
   input  wire logic [sbs_pkg::GRADE_W-1:0]    req_first_grade,
   input  wire logic [sbs_pkg::GRADE_W-1:0]    req_second_grade,
   input  wire logic [sbs_pkg::ID_W-1:0]       req_search_key,
   output logic                                rsp_valid,
   output logic      [sbs_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [sbs_pkg::INDEX_W-1:0]    rsp_found_index,
   output logic      [sbs_pkg::ID_W-1:0]       rsp_found_id,
   output logic      [sbs_pkg::GRADE_W-1:0]    rsp_final_grade
);

   import sbs_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic [ID_W-1:0]          key_ff, key_in;
   logic [ID_W-1:0]          hit_id_ff, hit_id_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [GRADE_W-1:0]       rsp_grade_ff, rsp_grade_in;

   logic                     accept;
   logic                     table_full;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [REC_W-1:0]         ram_wr_data;
   logic [REC_W-1:0]         ram_rd_data;
   logic [ID_W-1:0]          rd_id;
   logic [GRADE_W-1:0]       rd_first;
   logic [GRADE_W-1:0]       rd_second;
   logic                     key_hit;
   logic [CNT_W-1:0]         mid_ext;
   logic [CNT_W-1:0]         next_lo;
   logic [CNT_W-1:0]         next_hi;
   logic [CNT_W-1:0]         next_mid;
   logic                     probe_go;
   logic [PROD_W-1:0]        grade_prod;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));

   assign ram_wr_data = {req_record_id, req_first_grade, req_second_grade};
   assign rd_id       = ram_rd_data[REC_W-1 -: ID_W];
   assign rd_first    = ram_rd_data[2*GRADE_W-1 -: GRADE_W];
   assign rd_second   = ram_rd_data[GRADE_W-1:0];
   assign key_hit     = (rd_id == key_ff);
   assign mid_ext     = CNT_W'(mid_ff);
   assign grade_prod  = PROD_W'(sum_ff) * PROD_W'(GRADE_RECIP);

   sbs_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared halving unit: starts or narrows the range and picks the next midpoint.
   always_comb begin
      if (state_ff == ST_PROBE) begin
         if (key_ff < rd_id) begin
            next_lo = lo_ff;
            next_hi = mid_ext;
         end else begin
            next_lo = mid_ext + CNT_W'(1);
            next_hi = hi_ff;
         end
      end else begin
         next_lo = '0;
         next_hi = count_ff;
      end
      probe_go = (next_lo < next_hi);
      next_mid = next_lo + ((next_hi - next_lo - CNT_W'(1)) >> 1);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_SEARCH) && probe_go) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (key_hit) begin
               state_in = ST_GRADE;
            end else if (!probe_go) begin
               state_in = ST_IDLE;
            end
         end
         ST_GRADE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      hit_id_in     = hit_id_ff;
      sum_in        = sum_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = next_mid[IDX_W-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_MISSING;
      rsp_index_in  = '0;
      rsp_id_in     = '0;
      rsp_grade_in  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_cmd)
                  CMD_CLEAR: begin
                     count_in      = '0;
                     rsp_status_in = STATUS_CLEARED;
                  end
                  CMD_APPEND: begin
                     if (table_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ram_wr_en     = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = STATUS_APPENDED;
                        rsp_index_in  = INDEX_W'(count_ff[IDX_W-1:0]);
                     end
                  end
                  CMD_SEARCH: begin
                     key_in = req_search_key;
                     lo_in  = next_lo;
                     hi_in  = next_hi;
                     mid_in = next_mid[IDX_W-1:0];
                     if (probe_go) begin
                        ram_rd_en    = 1'b1;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_MISSING;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (key_hit) begin
               hit_id_in = rd_id;
               sum_in    = SUM_W'(rd_first) + (SUM_W'(rd_second) << 1) + SUM_W'(1);
            end else if (probe_go) begin
               lo_in     = next_lo;
               hi_in     = next_hi;
               mid_in    = next_mid[IDX_W-1:0];
               ram_rd_en = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_GRADE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_FOUND;
            rsp_index_in  = INDEX_W'(mid_ff);
            rsp_id_in     = hit_id_ff;
            rsp_grade_in  = GRADE_W'(grade_prod >> GRADE_SHIFT);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      hit_id_ff     <= hit_id_in;
      sum_ff        <= sum_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_grade_ff  <= rsp_grade_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_found_id    = rsp_id_ff;
   assign rsp_final_grade = rsp_grade_ff;

   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe raised while a transaction is still in progress");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> ((mid_ext >= lo_ff) && (mid_ext < hi_ff) && (hi_ff <= count_ff)))
      else $error("probe index outside the search range");

   a_found_after_grade: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FOUND)) |-> ($past(state_ff) == ST_GRADE))
      else $error("found reported without a grade step");

   a_hit_goes_to_grade: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PROBE) && key_hit) |=> (state_ff == ST_GRADE))
      else $error("matching probe did not move to the grade step");

endmodule
`default_nettype wire
